// File: hw/rtl/prime_filter_trial_division_top_macros.svh
// Assertion macros for the prime filter block.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef PRIME_FILTER_TRIAL_DIVISION_TOP_MACROS_SVH
`define PRIME_FILTER_TRIAL_DIVISION_TOP_MACROS_SVH

// Property checked at every clock edge outside reset.
`define PFT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication, checked outside reset.
`define PFT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

// File: hw/rtl/pft_pkg.sv
// Shared types and constants of the prime filter block.
// No dependencies; used by every RTL module of the block.
`timescale 1ns / 1ps

package pft_pkg;

  localparam int unsigned DataWidth   = 32;
  localparam int unsigned CountWidth  = 16;
  // magnitude of a positive input, sign bit dropped
  localparam int unsigned MagWidth    = DataWidth - 1;
  // trial divisor never exceeds sqrt(2^(DataWidth-1))
  localparam int unsigned DivWidth    = DataWidth / 2 + 1;
  localparam int unsigned SqWidth     = DataWidth + 1;
  localparam int unsigned RemWidth    = DivWidth + 1;
  localparam int unsigned BitCntWidth = $clog2(MagWidth);

  typedef struct packed {
    logic signed [DataWidth-1:0] value;
    logic                        last_in;
  } pft_in_t;

  typedef struct packed {
    logic signed [DataWidth-1:0]  value_out;
    logic                         is_prime;
    logic        [CountWidth-1:0] prime_count;
    logic                         last_out;
  } pft_out_t;

  // sequencer -> remainder unit
  typedef struct packed {
    logic                start;
    logic [MagWidth-1:0] dividend;
    logic [DivWidth-1:0] divisor;
  } pft_rem_req_t;

  // remainder unit -> sequencer
  typedef struct packed {
    logic done;
    logic is_zero;
  } pft_rem_rsp_t;

  // top -> tester
  typedef struct packed {
    logic                        start;
    logic                        ack;
    logic signed [DataWidth-1:0] value;
  } pft_tst_req_t;

  // tester -> top
  typedef struct packed {
    logic done;
    logic prime;
  } pft_tst_rsp_t;

endpackage

// File: hw/rtl/prime_filter_trial_division_top.sv
// Prime filter, trial division. Usage:
// - Input channel in_valid_i / in_stall_o / in_data_i carries one integer
//   and a last-of-batch mark per transaction.
// - Output channel out_valid_o / out_stall_i / out_data_o returns the value,
//   a prime flag, the saturating prime count of the batch so far including
//   this item, and the last mark. One result per input.
// - One item in flight: in_stall_o is high from acceptance until its result
//   is moved into the output register. A finished result may wait there
//   while the next item is already under test.
// - Values below two skip the test and go straight to the result. A prime is
//   tried against k divisors (k = 0 for 2 and 3); a composite stops at the
//   j-th divisor, the first that divides it. Worst case is a 31-bit prime,
//   k ~46340. Each divisor costs a square check, a 31-step bit-serial
//   remainder and a result check on one shared unit; that loop sets the
//   throughput, the next input goes in as the result can first leave.
// - Stalls on the output only delay the hand-off into the output register.
// - Reset (rst_ni low, asynchronous) empties the pipe and clears the batch
//   count to zero; the count also clears after an item marked last.
// Depends on pft_pkg, pft_tester and the assertion macro header.
`timescale 1ns / 1ps
`include "prime_filter_trial_division_top_macros.svh"

module prime_filter_trial_division_top
  import pft_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  pft_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output pft_out_t out_data_o
);

  localparam logic [CountWidth-1:0] CountMax = '1;

  logic                        busy_q, busy_d;
  logic                        out_valid_q, out_valid_d;
  pft_out_t                    out_q, out_d;
  logic [CountWidth-1:0]       cnt_q, cnt_d;
  logic [CountWidth-1:0]       cnt_new;
  logic signed [DataWidth-1:0] value_q;
  logic                        last_q;
  logic                        in_acc;
  logic                        load;
  pft_tst_req_t                tst_req;
  pft_tst_rsp_t                tst_rsp;

  assign in_stall_o = busy_q;
  assign in_acc     = in_valid_i & ~busy_q;

  // result moves into the output register once that register is free or its result is being taken
  assign load = tst_rsp.done & (~out_valid_q | ~out_stall_i);

  assign tst_req.start = in_acc;
  assign tst_req.ack   = load;
  assign tst_req.value = in_data_i.value;

  pft_tester u_tester (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (tst_req),
    .rsp_o  (tst_rsp)
  );

  // saturating batch count
  assign cnt_new = (tst_rsp.prime && (cnt_q != CountMax)) ? cnt_q + 1'b1 : cnt_q;

  always_comb begin
    busy_d      = busy_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_d       = out_q;
    cnt_d       = cnt_q;
    if (in_acc) begin
      busy_d = 1'b1;
    end
    if (load) begin
      busy_d            = 1'b0;
      out_valid_d       = 1'b1;
      out_d.value_out   = value_q;
      out_d.is_prime    = tst_rsp.prime;
      out_d.prime_count = cnt_new;
      out_d.last_out    = last_q;
      cnt_d             = last_q ? '0 : cnt_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (in_acc) begin
      value_q <= in_data_i.value;
      last_q  <= in_data_i.last_in;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a finished test only appears for an accepted item
  `PFT_IMPLIES(a_done_needs_busy, tst_rsp.done, busy_q, "test done with no item in flight")
  // end of batch clears the count
  `PFT_ASSERT(a_last_clears, load && last_q |=> cnt_q == '0, "count not cleared after last")
  // non-prime never moves the count
  `PFT_IMPLIES(a_nonprime_hold, load && !tst_rsp.prime, cnt_new == cnt_q, "count moved on non-prime")
  // hand-off frees the input side
  `PFT_ASSERT(a_load_frees, load |=> !busy_q, "input still stalled after hand-off")

endmodule

// File: hw/rtl/pft_rem.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on pft_pkg.
`timescale 1ns / 1ps

module pft_rem
  import pft_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  pft_rem_req_t req_i,
  output pft_rem_rsp_t rsp_o
);

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [BitCntWidth-1:0] cnt_q, cnt_d;
  logic [MagWidth-1:0]    dvd_q, dvd_d;
  logic [DivWidth-1:0]    dvs_q, dvs_d;
  logic [RemWidth-1:0]    rem_q, rem_d;
  logic [RemWidth-1:0]    rem_shift;
  logic [RemWidth-1:0]    dvs_ext;

  assign rem_shift = {rem_q[RemWidth-2:0], dvd_q[MagWidth-1]};
  assign dvs_ext   = {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = BitCntWidth'(MagWidth - 1);
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[MagWidth-2:0], 1'b0};
      rem_d = (rem_shift >= dvs_ext) ? (rem_shift - dvs_ext) : rem_shift;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.is_zero = (rem_q == '0);

endmodule

// File: hw/rtl/pft_tester.sv
// Trial-division sequencer: steps the divisor and its square, drives the
// remainder unit. Depends on pft_pkg and pft_rem.
`timescale 1ns / 1ps

module pft_tester
  import pft_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  pft_tst_req_t req_i,
  output pft_tst_rsp_t rsp_o
);

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StCheck = 4'b0010,
    StDiv   = 4'b0100,
    StDone  = 4'b1000
  } tst_state_e;

  tst_state_e          state_q, state_d;
  logic [MagWidth-1:0] mag_q, mag_d;
  logic [DivWidth-1:0] div_q, div_d;
  logic [SqWidth-1:0]  sq_q, sq_d;
  logic                prime_q, prime_d;
  logic                below_two;
  logic                past_root;
  pft_rem_req_t        rem_req;
  pft_rem_rsp_t        rem_rsp;

  // negative, zero or one
  assign below_two = req_i.value[DataWidth-1] | (req_i.value[DataWidth-1:1] == '0);
  assign past_root = sq_q > SqWidth'(mag_q);

  always_comb begin
    state_d          = state_q;
    mag_d            = mag_q;
    div_d            = div_q;
    sq_d             = sq_q;
    prime_d          = prime_q;
    rem_req.start    = 1'b0;
    rem_req.dividend = mag_q;
    rem_req.divisor  = div_q;
    case (state_q)
      StIdle: begin
        if (req_i.start) begin
          mag_d = req_i.value[MagWidth-1:0];
          div_d = DivWidth'(2);
          sq_d  = SqWidth'(4);
          if (below_two) begin
            prime_d = 1'b0;
            state_d = StDone;
          end else begin
            state_d = StCheck;
          end
        end
      end
      StCheck: begin
        if (past_root) begin
          prime_d = 1'b1;
          state_d = StDone;
        end else begin
          rem_req.start = 1'b1;
          state_d       = StDiv;
        end
      end
      StDiv: begin
        if (rem_rsp.done) begin
          if (rem_rsp.is_zero) begin
            prime_d = 1'b0;
            state_d = StDone;
          end else begin
            // (d+1)^2 = d^2 + 2d + 1
            sq_d    = sq_q + SqWidth'({div_q, 1'b1});
            div_d   = div_q + 1'b1;
            state_d = StCheck;
          end
        end
      end
      StDone: begin
        if (req_i.ack) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  pft_rem u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .rsp_o  (rem_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q   <= mag_d;
    div_q   <= div_d;
    sq_q    <= sq_d;
    prime_q <= prime_d;
  end

  assign rsp_o.done  = (state_q == StDone);
  assign rsp_o.prime = prime_q;

endmodule

// File: sim/prime_filter_trial_division_top_test.sv
// Testbench for prime_filter_trial_division_top: trial-division prime flag and batch count.
// Self-checking with a scoreboard class that predicts each result; needs pft_pkg and the RTL.
`timescale 1ns / 1ps

module prime_filter_trial_division_top_test;
  import pft_pkg::*;

  // Predicts the flag and the saturating batch count for every accepted
  // input transaction and compares the results in order.
  class prime_batch_scoreboard;
    logic [CountWidth-1:0] batch_primes;
    pft_out_t              expected_q[$];
    int                    errors;

    function new();
      batch_primes = '0;
      errors       = 0;
    endfunction

    function bit value_is_prime(logic signed [DataWidth-1:0] v);
      longint unsigned m;
      longint unsigned d;
      if (v < 2) return 1'b0;
      m = v;
      for (d = 2; d * d <= m; d++) begin
        if (m % d == 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_input(pft_in_t item);
      pft_out_t want;
      want.value_out = item.value;
      want.is_prime  = value_is_prime(item.value);
      if (want.is_prime && batch_primes != '1) batch_primes++;
      want.prime_count = batch_primes;
      want.last_out    = item.last_in;
      if (item.last_in) batch_primes = '0;
      expected_q.push_back(want);
    endfunction

    function void check_result(pft_out_t got);
      pft_out_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected: %h", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.value_out !== want.value_out) begin
        $display("%0t: value_out expected %0d actual %0d", $time, want.value_out,
                 got.value_out);
        errors++;
      end
      if (got.is_prime !== want.is_prime) begin
        $display("%0t: is_prime for %0d expected %0b actual %0b", $time,
                 want.value_out, want.is_prime, got.is_prime);
        errors++;
      end
      if (got.prime_count !== want.prime_count) begin
        $display("%0t: prime_count for %0d expected %0d actual %0d", $time,
                 want.value_out, want.prime_count, got.prime_count);
        errors++;
      end
      if (got.last_out !== want.last_out) begin
        $display("%0t: last_out for %0d expected %0b actual %0b", $time,
                 want.value_out, want.last_out, got.last_out);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  pft_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  pft_out_t out_data_o;

  // while set, neither side idles
  bit steady = 1'b0;

  prime_batch_scoreboard board = new();

  prime_filter_trial_division_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Receiver back-pressure, changed on the falling edge only.
  always @(negedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(99) < 21);
  end

  // Output monitor: a transaction moves when valid is high and stall is low.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_result(out_data_o);
    end
  end

  // Drives one input transaction starting at a falling edge and returns at the
  // falling edge after it was taken. Valid stays high into the next call, so
  // back-to-back transactions never see valid drop and rise in one step.
  task automatic offer_value(logic signed [DataWidth-1:0] v, logic last);
    pft_in_t item;
    item.value   = v;
    item.last_in = last;
    while (!steady && $urandom_range(99) < 21) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_input(item);
    @(negedge clk_i);
  endtask

  // Sender holds off until every expected result has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (board.pending() != 0) @(negedge clk_i);
  endtask

  // Random value mix. Big positive values always carry a factor of 2 or 3 so
  // the block returns quickly; a 31-bit prime is tried against every divisor up to its root.
  function automatic logic signed [DataWidth-1:0] pick_value();
    logic [DataWidth-1:0] r;
    int unsigned          sel;
    sel = $urandom_range(99);
    r   = $urandom();
    if (sel < 40) return $urandom_range(200);
    if (sel < 55) return $urandom_range(5000, 200);
    if (sel < 62) return $urandom_range(60000, 10000);
    if (sel < 75) return {1'b1, r[DataWidth-2:0]};
    if (sel < 85) return {1'b0, r[DataWidth-2:1], 1'b0};
    return 3 * $urandom_range(715827882, 1);
  endfunction

  initial begin
    int batch_left;

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: values below two, smallest primes, prime squares at the
    // d*d <= n boundary, field extremes, and batch ends clearing the count.
    offer_value(0, 1'b0);
    offer_value(1, 1'b0);
    offer_value(-1, 1'b0);
    offer_value(32'sh8000_0000, 1'b0);
    offer_value(2, 1'b0);
    offer_value(3, 1'b1);                 // batch end: count back to zero
    offer_value(4, 1'b0);
    offer_value(5, 1'b0);
    offer_value(9, 1'b0);
    offer_value(25, 1'b0);
    offer_value(49, 1'b0);
    offer_value(97, 1'b1);
    offer_value(121, 1'b1);               // one-item batch, not prime
    offer_value(7, 1'b1);                 // one-item batch, prime
    offer_value(32'sh7FFF_FFFE, 1'b0);    // largest even
    offer_value(32'sh7FFF_FFFD, 1'b0);    // multiple of 5
    offer_value(65537, 1'b0);
    offer_value(1018081, 1'b0);           // 1009 squared
    offer_value(1000003, 1'b0);           // prime, ~1000 divisors
    offer_value(32'shFFFF_FFFE, 1'b1);
    drain_results();

    // Random batches; a stretch in the middle runs with no random idling, apart from one drain.
    batch_left = 0;
    for (int i = 0; i < 80; i++) begin
      steady = (i >= 25 && i < 55);
      if (batch_left == 0) batch_left = $urandom_range(8, 1);
      batch_left--;
      offer_value(pick_value(), batch_left == 0 || $urandom_range(9) == 0);
      if (i == 40) drain_results();
    end
    steady = 1'b0;

    drain_results();
    // catch any stray result
    repeat (100) @(negedge clk_i);
    if (board.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: ends the run with a mismatch message if the test has not finished.
  initial begin
    #40_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/pft_pkg.sv
hw/rtl/pft_rem.sv
hw/rtl/pft_tester.sv
hw/rtl/prime_filter_trial_division_top.sv
sim/prime_filter_trial_division_top_test.sv
